>>> src/pmac_pkg.sv
`timescale 1ns / 1ps

package pmac_pkg;

  // Result action codes.
  typedef enum logic [2:0] {
    ACT_HOP_EXPIRED = 3'd0,
    ACT_FW_BLOCK    = 3'd1,
    ACT_ROUTE_DROP  = 3'd2,
    ACT_ROUTED      = 3'd3,
    ACT_NAT         = 3'd4,
    ACT_SW_DROP     = 3'd5,
    ACT_SW_FWD      = 3'd6,
    ACT_SW_NONE     = 3'd7
  } action_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_PUB_HIGH = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_PUB_LOW  = 8'd1;

  localparam logic [63:0] PUB_HIGH_RST = 64'h6b6a_55b5_14ad_a4c6;
  localparam logic [63:0] PUB_LOW_RST  = 64'hbcbe_8ee2_8cec_917c;

  // Address prefixes, compared on the top bits of the upper address half.
  localparam logic [6:0]  PFX_FC00_7   = 7'b1111110;
  localparam logic [7:0]  PFX_FF00_8   = 8'hff;
  localparam logic [7:0]  PFX_FD00_8   = 8'hfd;
  localparam logic [7:0]  PFX_FA00_8   = 8'hfa;
  localparam logic [9:0]  PFX_FE80_10  = 10'b1111111010;
  localparam logic [63:0] ROUTE_DROP_HIGH = 64'hff00_0000_0000_0000;
  localparam logic [63:0] ROUTE_DROP_LOW  = 64'h0000_0000_0000_0114;

  localparam logic [15:0] PORT_HTTP  = 16'd80;
  localparam logic [15:0] PORT_SSH   = 16'd22;

  typedef struct packed {
    logic [63:0] dst_addr_high;
    logic [63:0] dst_addr_low;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [15:0] dst_port;
    logic [47:0] dst_mac;
    logic [7:0]  hop_cnt;
  } pkt_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  egress_port;
    logic [7:0]  next_hop_cnt;
    logic [63:0] out_src_high;
    logic [63:0] out_src_low;
  } res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] reg_idx;
    logic [63:0]        wdata;
  } cfg_t;

  typedef struct packed {
    logic [47:0] value;
    logic [5:0]  len;
    logic        drop;
    logic [2:0]  port;
  } mac_rule_t;

  localparam int unsigned MacRules = 10;

  localparam mac_rule_t MAC_TABLE [MacRules] = '{
    '{value: 48'h5254_0042_4200, len: 6'd40, drop: 1'b0, port: 3'd5},
    '{value: 48'h70B3_D5E6_F000, len: 6'd36, drop: 1'b1, port: 3'd0},
    '{value: 48'h0000_0C00_0000, len: 6'd24, drop: 1'b0, port: 3'd2},
    '{value: 48'h98CA_3300_0000, len: 6'd24, drop: 1'b0, port: 3'd3},
    '{value: 48'h0100_0000_0000, len: 6'd8,  drop: 1'b0, port: 3'd4},
    '{value: 48'h0200_0000_0000, len: 6'd8,  drop: 1'b0, port: 3'd1},
    '{value: 48'h0600_0000_0000, len: 6'd8,  drop: 1'b0, port: 3'd2},
    '{value: 48'h0A00_0000_0000, len: 6'd8,  drop: 1'b0, port: 3'd1},
    '{value: 48'h0E00_0000_0000, len: 6'd8,  drop: 1'b0, port: 3'd1},
    '{value: 48'h0F00_0000_0000, len: 6'd8,  drop: 1'b1, port: 3'd0}
  };

  // True when the top rule.len bits of mac equal those of the rule value.
  function automatic logic mac_hit(input logic [47:0] mac, input mac_rule_t rule);
    logic [47:0] mask;
    mask = {48{1'b1}} << (6'd48 - rule.len);
    return ((mac ^ rule.value) & mask) == 48'h0;
  endfunction

endpackage

>>> src/pmac_in_if.sv
`timescale 1ns / 1ps

interface pmac_in_if;
  import pmac_pkg::*;

  logic valid;
  logic ready;
  pkt_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/pmac_out_if.sv
`timescale 1ns / 1ps

interface pmac_out_if;
  import pmac_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/pmac_cfg_if.sv
`timescale 1ns / 1ps

interface pmac_cfg_if;
  import pmac_pkg::*;

  logic valid;
  logic ready;
  cfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/pmac_decide.sv
`timescale 1ns / 1ps

module pmac_decide (
  input  pmac_pkg::pkt_t     pkt_i,
  input  logic [63:0]        pub_high_i,
  input  logic [63:0]        pub_low_i,
  output pmac_pkg::res_t     res_o
);
  import pmac_pkg::*;

  logic [MacRules-1:0] mac_match;
  logic                in_fc7;
  logic                in_fd8;
  logic                in_ff8;
  logic                in_fa8;
  logic                in_fe10;
  logic                is_route_drop_host;

  always_comb begin
    for (int i = 0; i < MacRules; i++) begin
      mac_match[i] = mac_hit(pkt_i.dst_mac, MAC_TABLE[i]);
    end
  end

  assign in_fc7  = pkt_i.dst_addr_high[63:57] == PFX_FC00_7;
  assign in_fd8  = pkt_i.dst_addr_high[63:56] == PFX_FD00_8;
  assign in_ff8  = pkt_i.dst_addr_high[63:56] == PFX_FF00_8;
  assign in_fa8  = pkt_i.dst_addr_high[63:56] == PFX_FA00_8;
  assign in_fe10 = pkt_i.dst_addr_high[63:54] == PFX_FE80_10;
  assign is_route_drop_host = (pkt_i.dst_addr_high == ROUTE_DROP_HIGH) &&
                              (pkt_i.dst_addr_low == ROUTE_DROP_LOW);

  always_comb begin
    action_e     act;
    logic [2:0]  egress;
    logic        sw_hit;
    mac_rule_t   sw_rule;

    act     = ACT_SW_NONE;
    egress  = 3'd0;
    sw_hit  = 1'b0;
    sw_rule = MAC_TABLE[0];

    // Walk from the last rule up so that the first matching rule wins.
    for (int i = MacRules - 1; i >= 0; i--) begin
      if (mac_match[i]) begin
        sw_hit  = 1'b1;
        sw_rule = MAC_TABLE[i];
      end
    end

    res_o.out_src_high = pkt_i.src_addr_high;
    res_o.out_src_low  = pkt_i.src_addr_low;
    res_o.next_hop_cnt = pkt_i.hop_cnt - 8'd1;

    if (pkt_i.hop_cnt <= 8'd1) begin
      act = ACT_HOP_EXPIRED;
      res_o.next_hop_cnt = 8'd0;
    end else if (in_fc7 && pkt_i.dst_port == PORT_HTTP) begin
      act = ACT_FW_BLOCK;
    end else if (in_ff8 && pkt_i.dst_port == PORT_SSH) begin
      act = ACT_FW_BLOCK;
    end else if (is_route_drop_host || in_fa8) begin
      act = ACT_ROUTE_DROP;
    end else if (in_fd8) begin
      act    = ACT_ROUTED;
      egress = 3'd7;
    end else if (!in_fe10 && !in_fc7) begin
      act = ACT_NAT;
      res_o.out_src_high = pub_high_i;
      res_o.out_src_low  = pub_low_i;
    end else if (sw_hit) begin
      if (sw_rule.drop) begin
        act = ACT_SW_DROP;
      end else begin
        act    = ACT_SW_FWD;
        egress = sw_rule.port;
      end
    end

    res_o.action      = act;
    res_o.egress_port = egress;
  end

endmodule

>>> src/packet_match_action_classifier.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake     Payload
// pkt_i    in   valid/ready   parsed header fields of one frame
// res_o    out  valid/ready   action, egress port, hop limit, source address
// cfg_i    in   valid/ready   register index and 64-bit write data
//
// One frame per cycle sustained while res_o is not stalled; a result is offered on
// res_o once its frame has passed the input register and then the result register,
// the two pipeline registers around the rule compares.
// Reset clears both valid bits and loads the public address reset value.
// A stall on res_o backs up through the pipeline; empty stages keep taking
// frames. cfg_i is always ready.

module packet_match_action_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  pmac_in_if.sink    pkt_i,
  pmac_out_if.source res_o,
  pmac_cfg_if.sink   cfg_i
);
  import pmac_pkg::*;

  logic        in_vld_q;
  pkt_t        in_q;
  logic        res_vld_q;
  res_t        res_q;
  res_t        res_d;
  logic        in_rdy;
  logic        res_rdy;
  logic [63:0] pub_high_q;
  logic [63:0] pub_low_q;

  assign res_rdy     = !res_vld_q || res_o.ready;
  assign in_rdy      = !in_vld_q || res_rdy;
  assign pkt_i.ready = in_rdy;
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pub_high_q <= PUB_HIGH_RST;
      pub_low_q  <= PUB_LOW_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_idx)
        CFG_PUB_HIGH: pub_high_q <= cfg_i.data.wdata;
        CFG_PUB_LOW:  pub_low_q  <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        in_vld_q <= pkt_i.valid;
      end
      if (res_rdy) begin
        res_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && pkt_i.valid) begin
      in_q <= pkt_i.data;
    end
    if (res_rdy && in_vld_q) begin
      res_q <= res_d;
    end
  end

  pmac_decide u_decide (
    .pkt_i      (in_q),
    .pub_high_i (pub_high_q),
    .pub_low_i  (pub_low_q),
    .res_o      (res_d)
  );

  // An expired frame carries no egress port and a zero hop limit.
  a_expired_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.action == ACT_HOP_EXPIRED |->
      res_q.next_hop_cnt == 8'd0 && res_q.egress_port == 3'd0)
    else $error("expired frame with nonzero hop limit or egress port");

  // Only routed and forwarded frames name an egress port.
  a_egress_only_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.egress_port != 3'd0 |->
      res_q.action == ACT_ROUTED || res_q.action == ACT_SW_FWD)
    else $error("egress port set for an action without one");

  // A new result needs a frame held in the input register the cycle before.
  a_res_from_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> $past(in_vld_q))
    else $error("result appeared without a frame in the input register");

  // A non-translated result passes the source address through unchanged.
  a_nat_only_rewrites: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_rdy && in_vld_q && res_d.action != ACT_NAT |=>
      res_q.out_src_high == $past(in_q.src_addr_high) &&
      res_q.out_src_low == $past(in_q.src_addr_low))
    else $error("source address changed without translation");

endmodule
